/* src/wped_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wped_pkg
// Shared constants and types for the windowed poke edge detector.
// ----------------------------------------------------------------------------
package wped_pkg;

  localparam int CHANNELS  = 6;
  localparam int TIME_BITS = 32;
  localparam int CH_W      = 3;   // channel field width, fixed by the event format
  localparam int WIN_W     = 16;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  typedef logic [CHANNELS-1:0]  chan_mask_t;
  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CH_W-1:0]      chan_idx_t;

  // One window update that changed at least one channel
  typedef struct packed {
    time_t      now;      // time of the update
    chan_mask_t change;   // channels whose presence flipped
    chan_mask_t was;      // presence before the update (1 = exit on change)
  } upd_t;

endpackage
`default_nettype wire

/* src/wped_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wped channel interfaces
// Valid/ready channels for samples, events and the window register.
// ----------------------------------------------------------------------------
interface wped_in_if;
  logic                           valid;
  logic                           ready;
  logic [wped_pkg::TIME_BITS-1:0] now_ms;
  logic [wped_pkg::CHANNELS-1:0]  poke_levels;

  modport source (output valid, now_ms, poke_levels, input ready);
  modport sink   (input valid, now_ms, poke_levels, output ready);
endinterface

interface wped_out_if;
  logic                           valid;
  logic                           ready;
  logic [wped_pkg::CH_W-1:0]      channel;
  logic                           is_exit;
  logic [wped_pkg::TIME_BITS-1:0] event_time_ms;
  logic [wped_pkg::TIME_BITS-1:0] dwell_ms;
  logic                           last;

  modport source (output valid, channel, is_exit, event_time_ms, dwell_ms, last,
                  input ready);
  modport sink   (input valid, channel, is_exit, event_time_ms, dwell_ms, last,
                  output ready);
endinterface

interface wped_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [wped_pkg::WIN_W-1:0] window_ms;

  modport source (output valid, window_ms, input ready);
  modport sink   (input valid, window_ms, output ready);
endinterface
`default_nettype wire

/* src/windowed_poke_edge_detector_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_poke_edge_detector_unit
// Six-line windowed presence detector emitting entry/exit events with dwell.
// ----------------------------------------------------------------------------
// Use:
//   in_ch  : one beat per sample (now_ms, poke_levels). Taken every cycle
//            while the update queue has room, so one sample per clock.
//   cfg_ch : window_ms write, always ready; write only while idle.
//   out_ch : zero to six event beats per sample, channel order 0..5,
//            last set on the final beat of an update.
// Path: an update sample's first event passes the queue write on its
//   beat edge, then the record load and the output register.
// Throughput: one event per cycle from the back end while out_ch
//   accepts; an update holds it until each changed channel has its event.
//   The 4-deep update queue lets sampling run on during such bursts and
//   while out_ch stalls; in_ch.ready drops only once the queue is full.
// Reset (rst_n low, synchronous): window 5 ms, latches, presence and the
//   update time cleared, queue and output emptied. Entry times are not
//   cleared; each is written by an entry before any exit reads it.
// Stall: a held out_ch beat stays put; the back end waits, records pile
//   up in the queue, then the front end stops taking samples.
// ----------------------------------------------------------------------------
module windowed_poke_edge_detector_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  wped_in_if.sink   in_ch,
  wped_cfg_if.sink  cfg_ch,
  wped_out_if.source out_ch
);
  import wped_pkg::*;

  // front -> queue
  logic q_push;
  upd_t q_rec;
  // queue -> back
  logic q_pop;
  upd_t q_head;
  logic q_full;
  logic q_empty;

  // Latch/window timing, presence update
  wped_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_rec  (q_rec)
  );

  // Absorbs event bursts so sampling never waits on a single update
  wped_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_rec),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Per-channel event walk, entry time store, output register
  wped_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_head  (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

`ifndef NO_ASSERTIONS
  // front never posts into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("update posted into full queue");

  // events name a real channel
  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.channel < CH_W'(CHANNELS)))
    else $error("event channel out of range");

  // entry beats carry zero dwell
  a_entry_dwell: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.is_exit) |-> (out_ch.dwell_ms == '0))
    else $error("entry event with non-zero dwell");

  // nothing leaves straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

/* src/wped_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wped_front
// Latches sample highs, times the window and posts changed presence masks.
// ----------------------------------------------------------------------------
module wped_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  wped_in_if.sink           in_ch,
  wped_cfg_if.sink          cfg_ch,
  input  wire logic         q_full,
  output logic              q_push,
  output wped_pkg::upd_t    q_rec
);
  import wped_pkg::*;

  logic [WIN_W-1:0] window_r;
  chan_mask_t       caught_r, caught_nxt;
  chan_mask_t       present_r, present_nxt;
  time_t            last_upd_r, last_upd_nxt;
  chan_mask_t       seen;
  time_t            elapsed;
  logic             fire;
  logic             accept;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = ~q_full;
  assign accept       = in_ch.valid & in_ch.ready;

  assign seen    = caught_r | in_ch.poke_levels;
  assign elapsed = in_ch.now_ms - last_upd_r;
  assign fire    = elapsed >= time_t'(window_r);

  always_comb begin
    caught_nxt   = caught_r;
    present_nxt  = present_r;
    last_upd_nxt = last_upd_r;
    q_push       = 1'b0;
    if (accept) begin
      if (fire) begin
        caught_nxt   = '0;
        present_nxt  = seen;
        last_upd_nxt = in_ch.now_ms;
        q_push       = (seen ^ present_r) != '0;
      end else begin
        caught_nxt = seen;
      end
    end
  end

  assign q_rec.now    = in_ch.now_ms;
  assign q_rec.change = seen ^ present_r;
  assign q_rec.was    = present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= WIN_W'(5);
      caught_r   <= '0;
      present_r  <= '0;
      last_upd_r <= '0;
    end else begin
      if (cfg_ch.valid) begin
        window_r <= cfg_ch.window_ms;
      end
      caught_r   <= caught_nxt;
      present_r  <= present_nxt;
      last_upd_r <= last_upd_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/wped_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wped_queue
// Short FIFO of update records between front and back.
// ----------------------------------------------------------------------------
module wped_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire wped_pkg::upd_t push_rec,
  input  wire logic           pop,
  output wped_pkg::upd_t      head,
  output logic                full,
  output logic                empty
);
  import wped_pkg::*;

  upd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = count_r == (Q_PTR_W+1)'(Q_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/wped_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wped_back
// Walks each update record one channel per beat; keeps entry times.
// ----------------------------------------------------------------------------
module wped_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire wped_pkg::upd_t q_head,
  input  wire logic           q_empty,
  output logic                q_pop,
  wped_out_if.source          out_ch
);
  import wped_pkg::*;

  logic       cur_valid_r;
  chan_mask_t cur_mask_r;
  chan_mask_t cur_was_r;
  time_t      cur_now_r;
  time_t      entry_r [CHANNELS];

  logic       out_valid_r;
  chan_idx_t  out_chan_r;
  logic       out_exit_r;
  time_t      out_time_r;
  time_t      out_dwell_r;
  logic       out_last_r;

  chan_idx_t  idx;
  chan_mask_t rest;
  logic       emit, fin, load, is_exit;

  // lowest pending channel first
  always_comb begin
    idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (cur_mask_r[i]) begin
        idx = CH_W'(i);
      end
    end
  end

  assign rest    = cur_mask_r & ~(chan_mask_t'(1) << idx);
  assign is_exit = cur_was_r[idx];
  assign emit    = cur_valid_r & (~out_valid_r | out_ch.ready);
  assign fin     = emit & (rest == '0);
  assign load    = ~cur_valid_r | fin;
  assign q_pop   = load & ~q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
    end else if (fin) begin
      cur_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_mask_r <= q_head.change;
      cur_was_r  <= q_head.was;
      cur_now_r  <= q_head.now;
    end else if (emit) begin
      cur_mask_r <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && !is_exit) begin
      entry_r[idx] <= cur_now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_chan_r  <= idx;
      out_exit_r  <= is_exit;
      out_time_r  <= cur_now_r;
      out_dwell_r <= is_exit ? (cur_now_r - entry_r[idx]) : '0;
      out_last_r  <= rest == '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.channel       = out_chan_r;
  assign out_ch.is_exit       = out_exit_r;
  assign out_ch.event_time_ms = out_time_r;
  assign out_ch.dwell_ms      = out_dwell_r;
  assign out_ch.last          = out_last_r;

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: windowed poke edge detector testbench
// Sample beats drive the detector through directed and random windows at
// several window settings. A local presence tracker predicts each entry and
// exit event, and every event beat is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import wped_pkg::*;

  localparam int SETTLE = 10;      // cycles allowed after the last beat
  localparam int LIMIT  = 200000;  // hard stop on the cycle counter

  typedef struct packed {
    time_t      now;
    chan_mask_t levels;
  } sample_t;

  typedef struct packed {
    chan_idx_t channel;
    logic      is_exit;
    time_t     event_time;
    time_t     dwell;
    logic      last;
  } dwell_event_t;

  logic clk;
  logic rst_n;

  wped_in_if  in_ch ();
  wped_cfg_if cfg_ch ();
  wped_out_if out_ch ();

  windowed_poke_edge_detector_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  // Tracker state, kept in step with the block on every accepted beat
  logic [WIN_W-1:0] window_now;
  chan_mask_t       caught_now;
  chan_mask_t       present_now;
  time_t            last_update_at;
  time_t            entered_at [CHANNELS];

  sample_t      sample_queue [$];   // beats still to be offered
  dwell_event_t event_queue  [$];   // events predicted, not yet seen
  dwell_event_t head_event;

  int          errors;
  int          n_samples;
  int          n_events;
  int          n_writes;
  int          cycles;
  int          in_gap;
  int          out_gap;
  bit          quiet;               // no idling on either side when set
  time_t       cur_time;
  time_t       base_time;
  int unsigned rand_window;

  // --------------------------------------------------------------------------
  // Clock, period 10
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Presence tracker: latch highs, and at a window boundary emit one event
  // per channel that flipped, in channel order, last on the final one.
  // Elapsed time and dwell wrap at the width of time_t.
  // --------------------------------------------------------------------------
  task automatic track_presence(input time_t now, input chan_mask_t levels);
    chan_mask_t   change;
    dwell_event_t ev;
    caught_now = caught_now | levels;
    if (time_t'(now - last_update_at) < time_t'(window_now))
      return;
    last_update_at = now;
    change = present_now ^ caught_now;
    for (int i = 0; i < CHANNELS; i++) begin
      if (change[i]) begin
        ev.channel    = chan_idx_t'(i);
        ev.is_exit    = present_now[i];
        ev.event_time = now;
        ev.dwell      = present_now[i] ? time_t'(now - entered_at[i]) : '0;
        ev.last       = ((change >> (i + 1)) == '0);
        if (!present_now[i])
          entered_at[i] = now;
        present_now[i] = ~present_now[i];
        event_queue.push_back(ev);
      end
    end
    caught_now = '0;
  endtask

  task automatic check_field(input string name, input logic [TIME_BITS-1:0] want,
                             input logic [TIME_BITS-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic push_sample(input time_t now, input chan_mask_t levels);
    sample_t s;
    s.now    = now;
    s.levels = levels;
    sample_queue.push_back(s);
  endtask

  // Empty windows half the time so that exits happen, some full ones for bursts of six
  function automatic chan_mask_t pick_levels();
    case ($urandom_range(0, 5))
      0, 1, 2: return '0;
      3:       return chan_mask_t'($urandom());
      4:       return chan_mask_t'(1) << $urandom_range(0, CHANNELS - 1);
      default: return '1;
    endcase
  endfunction

  // Time moves on by small steps, now and then by a random jump that may wrap
  task automatic random_burst(input int count, input int unsigned max_step);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 19) == 0)
        cur_time = cur_time + time_t'($urandom());
      else
        cur_time = cur_time + time_t'($urandom_range(0, max_step));
      push_sample(cur_time, pick_levels());
    end
  endtask

  // All beats taken and all events seen, then a margin for the pipeline
  task automatic wait_idle();
    while (sample_queue.size() != 0 || event_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.window_ms <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    window_now = w;
    n_writes++;
    cfg_ch.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sample driver: offers the head of the queue, holds a beat until taken,
  // and inserts random idle bursts between beats.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        track_presence(in_ch.now_ms, in_ch.poke_levels);
        void'(sample_queue.pop_front());
        n_samples++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // beat still on offer, hold it
      end else if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (sample_queue.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 2);
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid       <= 1'b1;
        in_ch.now_ms      <= sample_queue[0].now;
        in_ch.poke_levels <= sample_queue[0].levels;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Event monitor: each taken beat against the oldest prediction; the
  // ready side stalls in random bursts.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_events++;
        if (event_queue.size() == 0) begin
          errors++;
          $display("%0t: expected no event, got channel %0d exit %0b time %0h dwell %0h",
                   $time, out_ch.channel, out_ch.is_exit, out_ch.event_time_ms,
                   out_ch.dwell_ms);
        end else begin
          head_event = event_queue.pop_front();
          check_field("channel", time_t'(head_event.channel), time_t'(out_ch.channel));
          check_field("is_exit", time_t'(head_event.is_exit), time_t'(out_ch.is_exit));
          check_field("event_time_ms", head_event.event_time, out_ch.event_time_ms);
          check_field("dwell_ms", head_event.dwell, out_ch.dwell_ms);
          check_field("last", time_t'(head_event.last), time_t'(out_ch.last));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed beats at the reset window, then random phases
  // at window 0, 65535, 1, a random value and back to 5.
  // --------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.now_ms       = '0;
    in_ch.poke_levels  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.window_ms   = '0;
    out_ch.ready       = 1'b0;
    window_now         = 16'd5;
    caught_now         = '0;
    present_now        = '0;
    last_update_at     = '0;
    errors             = 0;
    n_samples          = 0;
    n_events           = 0;
    n_writes           = 0;
    cycles             = 0;
    quiet              = 1'b0;
    cur_time           = '0;

    // Directed, reset window of 5
    push_sample(32'd0, 6'h00);            // elapsed 0, no update
    push_sample(32'd1, 6'h3F);
    push_sample(32'd5, 6'h00);            // exactly one window: six entries
    push_sample(32'd10, 6'h00);           // six exits, dwell 5
    push_sample(32'd11, 6'h01);
    push_sample(32'd12, 6'h20);
    push_sample(32'd15, 6'h00);           // entries on 0 and 5
    push_sample(32'd20, 6'h21);           // no change, latches cleared
    push_sample(32'd25, 6'h01);           // exit on 5
    push_sample(32'd29, 6'h00);           // one short of the window
    push_sample(32'd30, 6'h00);           // exit on 0, dwell 15
    push_sample(32'hFFFF_FFF0, 6'h3F);    // entries near the top of time
    push_sample(32'h0000_0003, 6'h00);    // wrap: exits, dwell 13h
    push_sample(32'hFFFF_FFFF, 6'h2A);
    push_sample(32'h0000_0002, 6'h15);    // elapsed 3 across the wrap
    push_sample(32'h0000_0004, 6'h00);    // entries and exits interleaved
    push_sample(32'd9, 6'h00);
    push_sample(32'd9, 6'h3F);
    push_sample(32'd13, 6'h3F);
    push_sample(32'd14, 6'h00);
    push_sample(32'h8000_0000, 6'h00);    // long jump, six exits
    cur_time = 32'h8000_0000;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // Window 0: every beat is an update, same time twice gives dwell 0
    write_window(16'd0);
    push_sample(cur_time, 6'h3F);
    push_sample(cur_time, 6'h00);
    random_burst(60, 2);
    wait_idle();

    // Widest window, with the boundary hit from one below
    write_window(16'hFFFF);
    base_time = last_update_at;
    push_sample(time_t'(base_time + 32'd65534), 6'h01);
    push_sample(time_t'(base_time + 32'd65535), 6'h00);
    cur_time = time_t'(base_time + 32'd65535);
    random_burst(60, 30000);
    wait_idle();

    write_window(16'd1);
    random_burst(60, 1);
    wait_idle();

    rand_window = $urandom_range(2, 200);
    write_window(rand_window[WIN_W-1:0]);
    random_burst(60, rand_window / 2 + 1);
    wait_idle();

    write_window(16'd5);
    random_burst(60, 4);
    wait_idle();

    // Final stretch at full rate on both sides
    quiet = 1'b1;
    random_burst(60, 4);
    wait_idle();

    $display("tb: %0d sample beats, %0d event beats, %0d window writes", n_samples,
             n_events, n_writes);
    $display("tb: windows 5, 0, 65535, 1, %0d and 5, with time wrap", rand_window);
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

/* windowed_poke_edge_detector_unit.f */
src/wped_pkg.sv
src/wped_if.sv
src/wped_front.sv
src/wped_queue.sv
src/wped_back.sv
src/windowed_poke_edge_detector_unit.sv
tb/sv/tb.sv
